FILE: hdl/c3rm_pkg.sv
// c3rm_pkg: shared constants, types and register codes of the 3x3 convolution,
// ReLU and 2x2 max-pool block.
// No dependencies.
package c3rm_pkg;

    localparam int IMAGE_WIDTH  = 28;
    localparam int IMAGE_HEIGHT = 28;
    localparam int KERNEL_SIZE  = 3;
    localparam int POOL_DIM     = 2;

    localparam int CONV_W = IMAGE_WIDTH - KERNEL_SIZE + 1;
    localparam int CONV_H = IMAGE_HEIGHT - KERNEL_SIZE + 1;
    localparam int POOL_W = CONV_W / POOL_DIM;
    localparam int POOL_H = CONV_H / POOL_DIM;

    localparam int PIX_W     = 8;
    localparam int TAP_W     = 16;
    localparam int KROW_W    = KERNEL_SIZE * TAP_W;
    localparam int VAL_W     = 27;
    localparam int PROD_W    = PIX_W + TAP_W + 1;
    localparam int ROW_W     = PROD_W + 2;
    localparam int SUM_W     = ROW_W + 2;
    localparam int COL_W     = $clog2(IMAGE_WIDTH);
    localparam int ROW_CNT_W = $clog2(IMAGE_HEIGHT);
    localparam int PI_W      = (POOL_H > 1) ? $clog2(POOL_H) : 1;
    localparam int PJ_W      = (POOL_W > 1) ? $clog2(POOL_W) : 1;

    localparam int OUT_IDX_W  = 4;
    localparam int OUT_DATA_W = ((VAL_W + 2 * OUT_IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - VAL_W - 2 * OUT_IDX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KROW_W;
    localparam int STAGES     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 2'd2;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [VAL_W-1:0] val_t;
    // [0] = older row, [1] = newer row
    typedef logic [KERNEL_SIZE-2:0][PIX_W-1:0] line_t;
    // [row][column], column KERNEL_SIZE-1 is the newest
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] window_t;
    typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] kernel_t;

    typedef struct packed {
        logic            conv_en;
        logic            dj_first;
        logic            pool_en;
        logic            di_first;
        logic            emit;
        logic            last;
        logic [PI_W-1:0] pi;
        logic [PJ_W-1:0] pj;
    } meta_t;

    typedef struct packed {
        logic en;
        logic load;
        logic s1_live;
    } ctrl_t;

endpackage

FILE: hdl/conv3x3_relu_maxpool2x2_top.sv
// conv3x3_relu_maxpool2x2_top: streaming 3x3 convolution, ReLU and 2x2 max pool.
// Throughput: one pixel per cycle; the five-stage pipeline only halts while a
// finished cell waits in the output register and another one reaches the last stage.
// Reset: counters, window, kernel and running column max clear; memories are not cleared.
// Depends on c3rm_pkg, c3rm_window and c3rm_mac.
module conv3x3_relu_maxpool2x2_top
    import c3rm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // pixel
    input  logic                  s_axis_tuser,   // frame_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pooled_value, pool_row, pool_col
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    kernel_t                kernel_reg;
    logic [ROW_CNT_W-1:0]   row_cnt_reg;
    logic [COL_W-1:0]       col_cnt_reg;
    logic [ROW_CNT_W-1:0]   r0;
    logic [COL_W-1:0]       c0;
    logic [ROW_CNT_W-1:0]   ci;
    logic [COL_W-1:0]       cj;
    logic                   conv_ok;
    meta_t                  meta_next;
    logic [STAGES-1:0]      valid_reg;
    meta_t                  meta_reg [STAGES];
    logic                   en;
    logic                   accept;
    ctrl_t                  ctrl;
    window_t                win;
    val_t                   conv_val;
    val_t                   pcp_reg;
    val_t                   pool_mem [POOL_W];
    val_t                   pool_rd_reg;
    val_t                   pool_next;
    logic                   out_valid_reg;
    val_t                   out_val_reg;
    logic [OUT_IDX_W-1:0]   out_row_reg;
    logic [OUT_IDX_W-1:0]   out_col_reg;
    logic                   out_last_reg;
    meta_t                  m4;
    meta_t                  m5;

    assign m4 = meta_reg[STAGES-2];
    assign m5 = meta_reg[STAGES-1];

    assign en     = !(out_valid_reg && !m_axis_tready && valid_reg[STAGES-1] && m5.emit);
    assign accept = s_axis_tvalid && en;
    assign s_axis_tready = en;

    assign ctrl = '{en: en, load: accept, s1_live: valid_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KERNEL_TOP:    kernel_reg[0] <= cfg_data;
                REG_KERNEL_MID:    kernel_reg[1] <= cfg_data;
                REG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_data;
                default:           ;
            endcase
        end
    end

    // position and pool bookkeeping of the incoming pixel
    always_comb
    begin
        r0 = s_axis_tuser ? '0 : row_cnt_reg;
        c0 = s_axis_tuser ? '0 : col_cnt_reg;
        ci = r0 - ROW_CNT_W'(KERNEL_SIZE - 1);
        cj = c0 - COL_W'(KERNEL_SIZE - 1);
        conv_ok = (r0 >= ROW_CNT_W'(KERNEL_SIZE - 1)) && (c0 >= COL_W'(KERNEL_SIZE - 1))
               && (ci < ROW_CNT_W'(POOL_H * POOL_DIM))
               && (cj < COL_W'(POOL_W * POOL_DIM));
        meta_next.conv_en  = conv_ok;
        meta_next.dj_first = ((cj % POOL_DIM) == 0);
        meta_next.pool_en  = conv_ok && ((cj % POOL_DIM) == POOL_DIM - 1);
        meta_next.di_first = ((ci % POOL_DIM) == 0);
        meta_next.emit     = meta_next.pool_en && ((ci % POOL_DIM) == POOL_DIM - 1);
        meta_next.pi       = PI_W'(ci / POOL_DIM);
        meta_next.pj       = PJ_W'(cj / POOL_DIM);
        meta_next.last     = (meta_next.pi == PI_W'(POOL_H - 1))
                          && (meta_next.pj == PJ_W'(POOL_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (c0 == COL_W'(IMAGE_WIDTH - 1))
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= (r0 == ROW_CNT_W'(IMAGE_HEIGHT - 1)) ? '0 : r0 + 1'b1;
            end
            else
            begin
                col_cnt_reg <= c0 + 1'b1;
                row_cnt_reg <= r0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta_next;
            for (int s = 1; s < STAGES; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
            end
        end
    end

    c3rm_window u_window
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .px    (s_axis_tdata),
        .col   (c0),
        .win   (win)
    );

    c3rm_mac u_mac
    (
        .clk    (clk),
        .en     (en),
        .kernel (kernel_reg),
        .win    (win),
        .val    (conv_val)
    );

    // running max across the columns of the current pool cell in this row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcp_reg <= '0;
        end
        else if (en && valid_reg[STAGES-2] && m4.conv_en)
        begin
            if (m4.dj_first || (conv_val > pcp_reg))
            begin
                pcp_reg <= conv_val;
            end
        end
    end

    assign pool_next = (m5.di_first || (pcp_reg > pool_rd_reg)) ? pcp_reg : pool_rd_reg;

    // partial maxima per pooled column: read in stage 4, write back in stage 5
    always_ff @(posedge clk)
    begin
        if (en && valid_reg[STAGES-2] && m4.pool_en)
        begin
            pool_rd_reg <= pool_mem[m4.pj];
        end
        if (en && valid_reg[STAGES-1] && m5.pool_en)
        begin
            pool_mem[m5.pj] <= pool_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && valid_reg[STAGES-1] && m5.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_reg[STAGES-1] && m5.emit)
        begin
            out_val_reg  <= pool_next;
            out_row_reg  <= OUT_IDX_W'(m5.pi);
            out_col_reg  <= OUT_IDX_W'(m5.pj);
            out_last_reg <= m5.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_reg, out_row_reg, out_val_reg};
    assign m_axis_tlast  = out_last_reg;

    // stalls only when a finished cell cannot leave
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // pool memory read and write-back never overlap on consecutive stages
    a_pool_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        !(valid_reg[STAGES-2] && m4.pool_en && valid_reg[STAGES-1] && m5.pool_en))
        else $error("pool accesses too close together");

    // a cell leaving the last stage is presented next cycle
    a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_reg[STAGES-1] && m5.emit) |=> m_axis_tvalid)
        else $error("pool cell lost");

endmodule

FILE: hdl/c3rm_window.sv
// c3rm_window: line memory of the two previous rows and the 3x3 window registers.
// Depends on c3rm_pkg.
module c3rm_window
    import c3rm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    input  pixel_t           px,
    input  logic [COL_W-1:0] col,
    output window_t          win
);

    line_t            line_mem [IMAGE_WIDTH];
    line_t            rd_reg;
    line_t            fwd_data_reg;
    logic             fwd_reg;
    pixel_t           px_reg;
    logic [COL_W-1:0] col_reg;
    window_t          win_reg;
    line_t            old_line;
    line_t            wr_line;

    always_comb
    begin
        old_line   = fwd_reg ? fwd_data_reg : rd_reg;
        wr_line[0] = old_line[1];
        wr_line[1] = px_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rd_reg       <= line_mem[col];
            px_reg       <= px;
            col_reg      <= col;
            fwd_data_reg <= wr_line;
        end
        if (ctrl.en && ctrl.s1_live)
        begin
            line_mem[col_reg] <= wr_line;
        end
    end

    // same column written back while it is read: take the write data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            fwd_reg <= ctrl.s1_live && (col_reg == col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (ctrl.en && ctrl.s1_live)
        begin
            for (int m = 0; m < KERNEL_SIZE; m++)
            begin
                for (int n = 0; n < KERNEL_SIZE - 1; n++)
                begin
                    win_reg[m][n] <= win_reg[m][n+1];
                end
            end
            win_reg[0][KERNEL_SIZE-1] <= old_line[0];
            win_reg[1][KERNEL_SIZE-1] <= old_line[1];
            win_reg[2][KERNEL_SIZE-1] <= px_reg;
        end
    end

    assign win = win_reg;

endmodule

FILE: hdl/c3rm_mac.sv
// c3rm_mac: nine-tap multiply, two-level adder and ReLU.
// Depends on c3rm_pkg.
module c3rm_mac
    import c3rm_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  kernel_t kernel,
    input  window_t win,
    output val_t    val
);

    logic signed [PROD_W-1:0] prod_next [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0] prod_reg  [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [ROW_W-1:0]  row_next  [KERNEL_SIZE];
    logic signed [ROW_W-1:0]  row_reg   [KERNEL_SIZE];
    logic signed [SUM_W-1:0]  sum;

    always_comb
    begin
        for (int m = 0; m < KERNEL_SIZE; m++)
        begin
            for (int n = 0; n < KERNEL_SIZE; n++)
            begin
                prod_next[m][n] = $signed({1'b0, win[m][n]})
                                * $signed(kernel[m][n*TAP_W +: TAP_W]);
            end
        end
    end

    always_comb
    begin
        for (int m = 0; m < KERNEL_SIZE; m++)
        begin
            row_next[m] = '0;
            for (int n = 0; n < KERNEL_SIZE; n++)
            begin
                row_next[m] = row_next[m] + ROW_W'(prod_reg[m][n]);
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int m = 0; m < KERNEL_SIZE; m++)
        begin
            sum = sum + SUM_W'(row_reg[m]);
        end
        val = (sum > 0) ? VAL_W'(sum) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            row_reg  <= row_next;
        end
    end

endmodule
